### rtl/gst_pkg.sv
package gst_pkg;

   localparam int OP_W = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W = 6;
   localparam int GEN_W = 16;

   localparam int ROW_BITS = 16;
   localparam int ROW_SEL_W = $clog2(ROW_BITS);

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [SLOT_W-1:0] slot_index;
      logic [GEN_W-1:0] handle_generation;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0] result_slot;
      logic [GEN_W-1:0] result_generation;
   } rsp_type;

endpackage

### rtl/gst_chan_if.sv
interface gst_chan_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/gst_ram.sv
module gst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/gst_row_scan.sv
module gst_row_scan #(
   parameter int SLOTS = 64,
   parameter int ROW_AW = 2
) (
   input  logic [ROW_AW-1:0]            row,
   input  logic [gst_pkg::ROW_BITS-1:0] used,
   output logic                         found,
   output logic [gst_pkg::ROW_SEL_W-1:0] bit_index
);
   import gst_pkg::*;

   logic [ROW_BITS-1:0] free_bits;
   logic [ROW_AW+ROW_SEL_W-1:0] slot_num;

   always_comb begin
      for (int b = 0; b < ROW_BITS; b++) begin
         slot_num = {row, ROW_SEL_W'(b)};
         free_bits[b] = !used[b] && (32'(slot_num) < 32'(SLOTS));
      end
   end

   always_comb begin
      bit_index = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            bit_index = ROW_SEL_W'(b);
         end
      end
   end

   assign found = |free_bits;
endmodule

### rtl/generational_slot_table_unit.sv
// Generational slot table. Items arrive on req_if: an op (allocate, release
// or check), a slot index and a handle generation. Each item produces exactly
// one item on rsp_if with a status, a slot and that slot's generation.
// Allocate grants the lowest free slot; release frees a slot and bumps its
// generation; check compares a handle generation with the slot's generation.
// After reset the block clears its used map and its generation memory, with
// req_if.ready low, and then takes items.
// One item is handled at a time. Release, check and the unused op go from
// S_EXEC to S_OUT, which moves the result into the output register. Allocate
// scans the used map one 16-slot row per read of its single read port,
// alternating S_SCAN_CHK and S_SCAN_RD over the fully used rows; on a free
// slot it goes through S_ALLOC_GEN to S_OUT, and with a full table it goes
// from the S_SCAN_CHK of the last row straight to S_OUT.
// In every case req_if.ready returns high once S_OUT has handed the result on.
// The result sits in an output register. A stalled receiver does not keep the
// block from taking and working on the next item; the block only waits when a
// second result is ready before the first one has been taken.
module generational_slot_table_unit #(
   parameter int SLOTS = 64,
   parameter int GEN_BITS = 16
) (
   input logic clock,
   input logic reset,
   gst_chan_if.sink req_if,
   gst_chan_if.source rsp_if
);
   import gst_pkg::*;

   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int ROWS = (SLOTS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int WIDE_W = ROW_AW + ROW_SEL_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN_RD = 3'd2;
   localparam logic [2:0] S_SCAN_CHK = 3'd3;
   localparam logic [2:0] S_ALLOC_GEN = 3'd4;
   localparam logic [2:0] S_EXEC = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [SLOT_AW-1:0] clr_ff, clr_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [GEN_BITS-1:0] hgen_ff, hgen_in;
   logic in_range_ff, in_range_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [SLOT_AW-1:0] grant_ff, grant_in;
   rsp_type res_ff, res_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic used_wr_en, used_rd_en;
   logic [ROW_AW-1:0] used_wr_addr, used_rd_addr;
   logic [ROW_BITS-1:0] used_wr_data, used_rd_data;
   logic gen_wr_en, gen_rd_en;
   logic [SLOT_AW-1:0] gen_wr_addr, gen_rd_addr;
   logic [GEN_BITS-1:0] gen_wr_data, gen_rd_data;

   logic scan_found;
   logic [ROW_SEL_W-1:0] scan_bit;
   logic [WIDE_W-1:0] scan_slot;
   logic [WIDE_W-1:0] req_wide, held_wide, clr_wide;
   logic req_in_range;
   logic [GEN_BITS-1:0] gen_cur;
   logic out_free;

   gst_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROWS),
      .AW(ROW_AW)
   ) u_used_ram (
      .clock(clock),
      .wr_en(used_wr_en),
      .wr_addr(used_wr_addr),
      .wr_data(used_wr_data),
      .rd_en(used_rd_en),
      .rd_addr(used_rd_addr),
      .rd_data(used_rd_data)
   );

   gst_ram #(
      .WIDTH(GEN_BITS),
      .DEPTH(SLOTS),
      .AW(SLOT_AW)
   ) u_gen_ram (
      .clock(clock),
      .wr_en(gen_wr_en),
      .wr_addr(gen_wr_addr),
      .wr_data(gen_wr_data),
      .rd_en(gen_rd_en),
      .rd_addr(gen_rd_addr),
      .rd_data(gen_rd_data)
   );

   gst_row_scan #(
      .SLOTS(SLOTS),
      .ROW_AW(ROW_AW)
   ) u_row_scan (
      .row(row_ff),
      .used(used_rd_data),
      .found(scan_found),
      .bit_index(scan_bit)
   );

   assign scan_slot = {row_ff, scan_bit};
   assign req_wide = WIDE_W'(req_if.payload.slot_index);
   assign held_wide = WIDE_W'(slot_ff);
   assign clr_wide = WIDE_W'(clr_ff);
   assign req_in_range = (32'(req_if.payload.slot_index) < 32'(SLOTS));
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      slot_in = slot_ff;
      hgen_in = hgen_ff;
      in_range_in = in_range_ff;
      row_in = row_ff;
      grant_in = grant_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      used_wr_en = 1'b0;
      used_wr_addr = row_ff;
      used_wr_data = used_rd_data;
      used_rd_en = 1'b0;
      used_rd_addr = row_ff;
      gen_wr_en = 1'b0;
      gen_wr_addr = SLOT_AW'(slot_ff);
      gen_wr_data = gen_rd_data + GEN_BITS'(1);
      gen_rd_en = 1'b0;
      gen_rd_addr = SLOT_AW'(slot_ff);
      gen_cur = in_range_ff ? gen_rd_data : '0;

      unique case (state_ff)
         S_CLEAR: begin
            used_wr_en = 1'b1;
            used_wr_addr = clr_wide[WIDE_W-1:ROW_SEL_W];
            used_wr_data = '0;
            gen_wr_en = 1'b1;
            gen_wr_addr = clr_ff;
            gen_wr_data = '0;
            clr_in = clr_ff + SLOT_AW'(1);
            if (clr_ff == SLOT_AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               op_in = req_if.payload.op;
               slot_in = req_if.payload.slot_index;
               hgen_in = GEN_BITS'(req_if.payload.handle_generation);
               in_range_in = req_in_range;
               if (req_if.payload.op == OP_ALLOC) begin
                  row_in = '0;
                  used_rd_en = 1'b1;
                  used_rd_addr = '0;
                  state_in = S_SCAN_CHK;
               end else begin
                  used_rd_en = 1'b1;
                  used_rd_addr = req_wide[WIDE_W-1:ROW_SEL_W];
                  gen_rd_en = 1'b1;
                  gen_rd_addr = SLOT_AW'(req_if.payload.slot_index);
                  state_in = S_EXEC;
               end
            end
         end
         S_SCAN_RD: begin
            used_rd_en = 1'b1;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (scan_found) begin
               used_wr_en = 1'b1;
               used_wr_data = used_rd_data | (ROW_BITS'(1) << scan_bit);
               grant_in = SLOT_AW'(scan_slot);
               gen_rd_en = 1'b1;
               gen_rd_addr = SLOT_AW'(scan_slot);
               state_in = S_ALLOC_GEN;
            end else if (row_ff == ROW_AW'(ROWS - 1)) begin
               res_in.status = ST_FULL;
               res_in.result_slot = '0;
               res_in.result_generation = '0;
               state_in = S_OUT;
            end else begin
               row_in = row_ff + ROW_AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_ALLOC_GEN: begin
            res_in.status = ST_OK;
            res_in.result_slot = SLOT_W'(grant_ff);
            res_in.result_generation = GEN_W'(gen_rd_data);
            state_in = S_OUT;
         end
         S_EXEC: begin
            if (op_ff == OP_RELEASE && in_range_ff) begin
               gen_wr_en = 1'b1;
               gen_cur = gen_wr_data;
               used_wr_en = 1'b1;
               used_wr_addr = held_wide[WIDE_W-1:ROW_SEL_W];
               used_wr_data = used_rd_data
                  & ~(ROW_BITS'(1) << held_wide[ROW_SEL_W-1:0]);
            end
            res_in.status = (op_ff == OP_CHECK && gen_cur != hgen_ff) ? ST_MISMATCH : ST_OK;
            res_in.result_slot = slot_ff;
            res_in.result_generation = GEN_W'(gen_cur);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      slot_ff <= slot_in;
      hgen_ff <= hgen_in;
      in_range_ff <= in_range_in;
      row_ff <= row_in;
      grant_ff <= grant_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_if.ready
   ) else $error("item accepted during the clearing pass");

   a_one_item_at_a_time: assert property (
      @(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready
   ) else $error("second item accepted while one is in flight");

   a_grant_in_table: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_GEN) |-> (32'(grant_ff) < 32'(SLOTS))
   ) else $error("granted slot lies outside the table");

   a_full_reports_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_FULL)
         |-> (rsp_ff.result_slot == '0 && rsp_ff.result_generation == '0)
   ) else $error("table full result carries a slot or generation");

   a_scan_row_bounded: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (32'(row_ff) < 32'(ROWS))
   ) else $error("used map scan ran past the last row");
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import gst_pkg::*;

   localparam int TABLE_SLOTS = 1 << SLOT_W;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [SLOT_W-1:0] REPEAT_SLOT = 6'd37;
   localparam int REPEAT_RELEASES = 20;
   localparam int STALL_LIMIT = 4000;
   localparam int RECEIVER_HOLD = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 70;

   logic clock;
   logic reset;

   gst_chan_if #(.payload_type(req_type)) req_chan ();
   gst_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   generational_slot_table_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_chan.sink),
      .rsp_if(rsp_chan.source)
   );

   bit slot_busy[TABLE_SLOTS];
   logic [GEN_W-1:0] slot_gen[TABLE_SLOTS];
   rsp_type predicted_rsp_q[$];

   int error_count = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int full_count = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_table_op(input req_type item);
      rsp_type answer;
      int free_slot;
      int i;
      answer.status = ST_OK;
      answer.result_slot = item.slot_index;
      answer.result_generation = '0;
      case (item.op)
         OP_ALLOC: begin
            free_slot = -1;
            for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
               if (!slot_busy[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               answer.status = ST_FULL;
               answer.result_slot = '0;
            end else begin
               slot_busy[free_slot] = 1'b1;
               answer.result_slot = SLOT_W'(free_slot);
               answer.result_generation = slot_gen[free_slot];
            end
         end
         OP_RELEASE: begin
            slot_busy[item.slot_index] = 1'b0;
            slot_gen[item.slot_index] = slot_gen[item.slot_index] + 1'b1;
            answer.result_generation = slot_gen[item.slot_index];
         end
         OP_CHECK: begin
            answer.result_generation = slot_gen[item.slot_index];
            if (answer.result_generation != item.handle_generation) begin
               answer.status = ST_MISMATCH;
            end
         end
         default: answer.result_generation = slot_gen[item.slot_index];
      endcase
      return answer;
   endfunction

   function automatic req_type make_random_item(input int alloc_pct);
      req_type item;
      int pick;
      int base;
      int k;
      bit found;
      item.slot_index = SLOT_W'($urandom_range(TABLE_SLOTS - 1));
      item.handle_generation = GEN_W'($urandom);
      pick = $urandom_range(99);
      if (pick < alloc_pct) item.op = OP_ALLOC;
      else if (pick < alloc_pct + (100 - alloc_pct) / 2) item.op = OP_RELEASE;
      else if (pick < 95) item.op = OP_CHECK;
      else item.op = OP_UNUSED;
      if (item.op != OP_ALLOC && $urandom_range(9) < 8) begin
         base = $urandom_range(TABLE_SLOTS - 1);
         found = 1'b0;
         for (k = 0; k < TABLE_SLOTS; k++) begin
            if (!found && slot_busy[(base + k) % TABLE_SLOTS]) begin
               item.slot_index = SLOT_W'((base + k) % TABLE_SLOTS);
               found = 1'b1;
            end
         end
      end
      if (item.op == OP_CHECK) begin
         pick = $urandom_range(9);
         if (pick < 6) item.handle_generation = slot_gen[item.slot_index];
         else if (pick < 8) item.handle_generation = slot_gen[item.slot_index] - 1'b1;
      end
      return item;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                            input logic [GEN_W-1:0] handle);
      req_type item;
      rsp_type answer;
      item.op = op;
      item.slot_index = slot;
      item.handle_generation = handle;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      answer = predict_table_op(item);
      op_count[op]++;
      if (answer.status == ST_FULL) full_count++;
      if (answer.status == ST_MISMATCH) mismatch_count++;
      predicted_rsp_q = {predicted_rsp_q, answer};
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct,
                                   input int alloc_pct);
      req_type item;
      int n;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         item = make_random_item(alloc_pct);
         send_item(item.op, item.slot_index, item.handle_generation);
      end
      wait_for_results();
   endtask

   task automatic test_basic_ops();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_item(OP_ALLOC, 6'd0, 16'h0000);
      send_item(OP_ALLOC, 6'd0, 16'h0000);
      send_item(OP_CHECK, 6'd0, 16'h0000);
      send_item(OP_CHECK, 6'd0, 16'hFFFF);
      send_item(OP_RELEASE, 6'd0, 16'h0000);
      send_item(OP_CHECK, 6'd0, 16'h0000);
      send_item(OP_CHECK, 6'd0, 16'h0001);
      send_item(OP_ALLOC, 6'd0, 16'h0000);
      send_item(OP_RELEASE, 6'd63, 16'hFFFF);
      send_item(OP_RELEASE, 6'd63, 16'h0000);
      send_item(OP_CHECK, 6'd63, 16'h0002);
      send_item(OP_UNUSED, 6'd63, 16'hFFFF);
      send_item(OP_UNUSED, 6'd0, 16'h0000);
      send_item(OP_CHECK, 6'd1, 16'h8000);
      send_item(OP_ALLOC, 6'd63, 16'hFFFF);
      send_item(OP_RELEASE, 6'd2, 16'h5A5A);
      wait_for_results();
   endtask

   task automatic test_fill_table();
      int i;
      send_idle_pct = 31;
      recv_stall_pct = 31;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (!slot_busy[i]) send_item(OP_ALLOC, 6'd0, 16'h0000);
      end
      send_item(OP_ALLOC, 6'd0, 16'h0000);
      send_item(OP_ALLOC, 6'd63, 16'hFFFF);
      send_item(OP_RELEASE, 6'd40, 16'h0000);
      send_item(OP_RELEASE, 6'd63, 16'h0000);
      send_item(OP_ALLOC, 6'd0, 16'h0000);
      send_item(OP_ALLOC, 6'd0, 16'h0000);
      for (i = 0; i < TABLE_SLOTS; i++) begin
         send_item(OP_RELEASE, SLOT_W'(i), 16'h0000);
      end
      wait_for_results();
   endtask

   task automatic test_receiver_hold();
      req_type item;
      int n;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = RECEIVER_HOLD;
      for (n = 0; n < 12; n++) begin
         item = make_random_item(50);
         send_item(item.op, item.slot_index, item.handle_generation);
      end
      wait_for_results();
   endtask

   task automatic test_repeated_release();
      int n;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (n = 0; n < REPEAT_RELEASES; n++) begin
         send_item(OP_RELEASE, REPEAT_SLOT, 16'h0000);
      end
      send_item(OP_CHECK, REPEAT_SLOT, slot_gen[REPEAT_SLOT]);
      send_item(OP_RELEASE, REPEAT_SLOT, 16'h0000);
      send_item(OP_CHECK, REPEAT_SLOT, slot_gen[REPEAT_SLOT]);
      send_item(OP_CHECK, REPEAT_SLOT, 16'hFFFF);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      run_random_phase(PHASE_ITEMS, 0, 0, 40);
      run_random_phase(PHASE_ITEMS, 49, 0, 60);
      run_random_phase(PHASE_ITEMS, 0, 49, 30);
      run_random_phase(PHASE_ITEMS, 31, 31, 45);
   endtask

   initial begin : rsp_drain
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type oldest;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t unexpected result: expected none, actual status %0d slot %0d gen %0d",
                     $time, rsp_chan.payload.status, rsp_chan.payload.result_slot,
                     rsp_chan.payload.result_generation);
         end else begin
            oldest = predicted_rsp_q.pop_front();
            compare_field("status", 32'(oldest.status), 32'(rsp_chan.payload.status));
            compare_field("result_slot", 32'(oldest.result_slot),
                          32'(rsp_chan.payload.result_slot));
            compare_field("result_generation", 32'(oldest.result_generation),
                          32'(rsp_chan.payload.result_generation));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t timeout: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_gen[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_fill_table();
      test_receiver_hold();
      test_repeated_release();
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d allocates (%0d with a full table), %0d releases, %0d checks",
               op_count[OP_ALLOC], full_count, op_count[OP_RELEASE], op_count[OP_CHECK]);
      $display("(%0d stale), %0d unused-op items, repeated releases of one slot and long stalls.",
               mismatch_count, op_count[OP_UNUSED]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/gst_pkg.sv
rtl/gst_chan_if.sv
rtl/gst_ram.sv
rtl/gst_row_scan.sv
rtl/generational_slot_table_unit.sv
tb/tb.sv
